// ===== rtl/mm3_pkg.sv =====
// ----------------------------------------------------------------------------
// MurmurHash3 x86_32 shared definitions
// Constants, queue entry types and small bit functions used by the front,
// the queue and the back end of the streaming hash core.
// ----------------------------------------------------------------------------
package mm3_pkg;

  // Scramble, mix and finalizer constants of the x86_32 scheme.
  localparam logic [31:0] MM_C1  = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2  = 32'h1b873593;
  localparam logic [31:0] MM_ADD = 32'he6546b64;
  localparam logic [31:0] MM_F1  = 32'h85ebca6b;
  localparam logic [31:0] MM_F2  = 32'hc2b2ae35;
  localparam logic [31:0] MM_MUL = 32'd5;

  // Byte count of a full word.
  localparam logic [2:0] FULL_BYTES = 3'd4;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  // One scrambled item as the back end consumes it.
  typedef struct packed {
    logic [31:0] k;     // scrambled block, zero for an empty tail
    logic [2:0]  inc;   // bytes the item adds to the message length
    logic        full;  // apply the rotate-multiply-add step
    logic        last;  // final item of the message
  } mm3_entry_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } mm3_qstat_t;

  // Mask that keeps the valid tail bytes of a final word.
  function automatic logic [31:0] tail_mask(input logic [2:0] count);
    logic [31:0] mask;
    unique case (count)
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'h0000_0000;
    endcase
    return mask;
  endfunction

  function automatic logic [31:0] rotl15(input logic [31:0] x);
    return {x[16:0], x[31:17]};
  endfunction

  function automatic logic [31:0] rotl13(input logic [31:0] x);
    return {x[18:0], x[31:19]};
  endfunction

endpackage

// ===== rtl/mm3_front.sv =====
// ----------------------------------------------------------------------------
// MurmurHash3 front end
// Accepts items, classifies them as full words or tails, masks unused tail
// bytes and scrambles the block in two multiply stages before queueing it.
// ----------------------------------------------------------------------------
module mm3_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [31:0]         data_word,
  input  logic [2:0]          byte_count,
  input  logic                last,
  input  mm3_pkg::mm3_qstat_t q_stat,
  output logic                q_push,
  output mm3_pkg::mm3_entry_t q_data
);
  import mm3_pkg::*;

  logic        busy;
  logic [31:0] k1;
  logic [2:0]  inc;
  logic        full;
  logic        last_q;

  logic        accept;
  logic        word_full;
  logic [31:0] masked;

  // Classify the incoming item: a word is full unless it is a short final one.
  always_comb begin
    word_full = !last || (byte_count >= FULL_BYTES);
    masked    = word_full ? data_word : (data_word & tail_mask(byte_count));
  end

  // The held item leaves whenever the queue has room, so a new one may enter.
  assign q_push   = busy && !q_stat.full;
  assign in_stall = busy && q_stat.full;
  assign accept   = in_valid && !in_stall;

  // Second scramble stage feeds the queue directly.
  always_comb begin
    q_data.k    = rotl15(k1) * MM_C2;
    q_data.inc  = inc;
    q_data.full = full;
    q_data.last = last_q;
  end

  // First scramble stage and item hold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      if (accept) begin
        busy   <= 1'b1;
        k1     <= masked * MM_C1;
        inc    <= word_full ? FULL_BYTES : byte_count;
        full   <= word_full;
        last_q <= last;
      end else if (q_push) begin
        busy <= 1'b0;
      end
    end
  end

  // An item taken while another is held must push the held one out.
  a_accept_drains: assert property (@(posedge clk) disable iff (rst)
    (accept && busy) |-> q_push)
    else $error("front accepted an item over one that was not queued");

endmodule

// ===== rtl/mm3_queue.sv =====
// ----------------------------------------------------------------------------
// MurmurHash3 item queue
// A short register queue that decouples the scramble front from the
// accumulate and finalize back end.
// ----------------------------------------------------------------------------
module mm3_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mm3_pkg::mm3_entry_t wr_data,
  input  logic                pop,
  output mm3_pkg::mm3_entry_t rd_data,
  output mm3_pkg::mm3_qstat_t stat
);
  import mm3_pkg::*;

  mm3_entry_t             entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  logic do_push;
  logic do_pop;

  assign stat.full  = (count == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_data    = entries[rd_ptr];

  // Circular pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        entries[wr_ptr] <= wr_data;
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // The front must never offer an item to a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !stat.full)
    else $error("push into a full queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (QUEUE_PTR_W + 1)'(QUEUE_DEPTH))
    else $error("queue occupancy out of range");

endmodule

// ===== rtl/mm3_back.sv =====
// ----------------------------------------------------------------------------
// MurmurHash3 back end
// Mixes scrambled items into the running hash, counts message bytes and runs
// the fmix32 finalizer through ST_MIX1, ST_MIX2 and ST_EMIT into the output register.
// ----------------------------------------------------------------------------
module mm3_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [31:0]         cfg_data,
  input  mm3_pkg::mm3_entry_t q_head,
  input  mm3_pkg::mm3_qstat_t q_stat,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         hash_value
);
  import mm3_pkg::*;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_MIX1,
    ST_MIX2,
    ST_EMIT
  } state_t;

  state_t      state;
  logic [31:0] seed;
  logic [31:0] running_hash;
  logic [31:0] message_bytes;
  logic        in_message;
  logic [31:0] fin;

  logic [31:0] base_hash;
  logic [31:0] base_bytes;
  logic [31:0] mixed;
  logic [31:0] acc_hash;
  logic [31:0] acc_bytes;
  logic [31:0] fin_x;
  logic        out_load;

  // Accumulate step: a new message starts from the seed and a zero length.
  always_comb begin
    base_hash  = in_message ? running_hash : seed;
    base_bytes = in_message ? message_bytes : 32'd0;
    mixed      = base_hash ^ q_head.k;
    acc_hash   = q_head.full ? (rotl13(mixed) * MM_MUL + MM_ADD) : mixed;
    acc_bytes  = base_bytes + 32'(q_head.inc);
    fin_x      = acc_hash ^ acc_bytes;
  end

  assign q_pop    = (state == ST_ACC) && !q_stat.empty;
  assign out_load = (state == ST_EMIT) && (!out_valid || !out_stall);

  // Sequencer, hash state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_ACC;
      seed          <= 32'd0;
      running_hash  <= 32'd0;
      message_bytes <= 32'd0;
      in_message    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        seed <= cfg_data;
      end
      // A new result replaces the one being taken; otherwise a taken one clears.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_ACC: begin
          if (q_pop) begin
            running_hash  <= acc_hash;
            message_bytes <= acc_bytes;
            if (q_head.last) begin
              in_message <= 1'b0;
              fin        <= fin_x ^ (fin_x >> 16);
              state      <= ST_MIX1;
            end else begin
              in_message <= 1'b1;
            end
          end
        end
        ST_MIX1: begin
          fin   <= fin * MM_F1;
          state <= ST_MIX2;
        end
        ST_MIX2: begin
          fin   <= (fin ^ (fin >> 13)) * MM_F2;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_load) begin
            hash_value <= fin ^ (fin >> 16);
            state      <= ST_ACC;
          end
        end
      endcase
    end
  end

  // A final item closes the message and starts the finalizer.
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_head.last) |=> (!in_message && state == ST_MIX1))
    else $error("final item did not close the message");

  // A result appears only from the last finalizer step.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_EMIT))
    else $error("result raised outside the finalizer");

endmodule

// ===== rtl/murmur3_32_stream_hash_core.sv =====
// Streaming MurmurHash3 x86_32. A message arrives as little-endian 32-bit
// words, one item per cycle while in_stall is low; the item flagged last may
// carry 0 to 3 tail bytes, and byte_count is read only on that item. The seed
// register is sampled when the first item of a message reaches the back end,
// so write it only while the core is idle. Within a message the core
// sustains one item per cycle when not stalled: the front scrambles each
// word in two multiply stages and the back folds it into the running hash as
// it pops it from the queue. Each final item sends the back end through the
// MIX1, MIX2 and EMIT states, which finish the finalizer and load the output
// register; meanwhile the back end takes no new item and the two-entry queue
// and the front absorb up to three more. The result is held in the output
// register until taken, and the core keeps accepting meanwhile.
// ----------------------------------------------------------------------------
// MurmurHash3 x86_32 stream hash core
// Top level joining the scramble front, the item queue and the mix and
// finalize back end.
// ----------------------------------------------------------------------------
module murmur3_32_stream_hash_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] hash_value
);
  import mm3_pkg::*;

  mm3_entry_t q_wr_data;
  mm3_entry_t q_head;
  mm3_qstat_t q_stat;
  logic       q_push;
  logic       q_pop;

  // Front: classify and scramble each item.
  mm3_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last       (last),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_data     (q_wr_data)
  );

  // Queue between the two halves.
  mm3_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_head),
    .stat    (q_stat)
  );

  // Back: accumulate, finalize and deliver the hash.
  mm3_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .q_head     (q_head),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash_value (hash_value)
  );

endmodule
